FILE: rtl/bnc_pkg.sv
// bnc_pkg: shared widths and defaults for the 3x3 neighbour count unit
// no dependencies; used by the interfaces, the rtl modules and the checker

package bnc_pkg;

   // fixed field widths
   localparam int GRID_SIDE_W = 6;
   localparam int COUNT_W     = 4;
   localparam int COORD_W     = 5;

   // largest count a 3x3 window can give
   localparam int COUNT_MAX   = 9;

   // default map side limit and grid side after reset
   localparam int MAX_SIDE_DEF    = 32;
   localparam int GRID_SIDE_RESET = 32;

endpackage

FILE: rtl/bnc_if.sv
// bnc_req_if / bnc_rsp_if: valid/ready channels of the neighbour count unit
// depends on bnc_pkg for the field widths

interface bnc_req_if;
   logic valid;
   logic ready;
   logic cell_set;

   modport source (output valid, output cell_set, input ready);
   modport sink   (input valid, input cell_set, output ready);
endinterface

interface bnc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bnc_pkg::COUNT_W-1:0]   neighbour_count;
   logic [bnc_pkg::COORD_W-1:0]   out_row;
   logic [bnc_pkg::COORD_W-1:0]   out_col;
   logic                          last_of_run;
   logic                          end_of_frame;

   modport source (output valid, output neighbour_count, output out_row, output out_col,
                   output last_of_run, output end_of_frame, input ready);
   modport sink   (input valid, input neighbour_count, input out_row, input out_col,
                   input last_of_run, input end_of_frame, output ready);
endinterface

FILE: rtl/binary_3x3_neighbour_count_unit.sv
// binary_3x3_neighbour_count_unit: top level of the 3x3 neighbour count block
// depends on bnc_pkg, bnc_req_if / bnc_rsp_if and bnc_window
//
// req_chan carries one map cell per request in raster order; rsp_chan returns
// each cell's 3x3 count (0..9, centre included) with its row and column, in
// raster order, off-map cells counting as clear. request (r,c) releases
// (r-1,c-1), a last-column request also releases (r-1,side-1), and the bottom
// right request flushes the last row. last_of_run marks a request's final
// response, end_of_frame the bottom right cell. csr_we/csr_wdata set the side
// (0 acts as 1, above MAX_SIDE acts as MAX_SIDE) and restart the frame; write
// only while idle.
// accepted requests add their responses to the pending count, which loads
// the output register one per cycle while rsp_chan.ready is high. a request
// is taken every cycle except that req_chan.ready drops after a last-column
// request of row 1 onward (two responses) and after the bottom right request
// (side+2 responses; not on a 1x1 map) until one is left to load. a stalled
// receiver holds the response and, once responses back up, drops req_chan.ready.
// reset is synchronous: frame position, pending responses and response valid
// clear, and the side returns to 32 (limited to MAX_SIDE).

module binary_3x3_neighbour_count_unit #(
   parameter int MAX_SIDE = bnc_pkg::MAX_SIDE_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   bnc_req_if.sink                             req_chan,
   bnc_rsp_if.source                           rsp_chan,
   input  logic                                csr_we,
   input  logic [bnc_pkg::GRID_SIDE_W-1:0]     csr_wdata
);

   // position width and pending count width
   localparam int PW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int CW = PW + 2;
   localparam int RESET_SIDE = (bnc_pkg::GRID_SIDE_RESET > MAX_SIDE) ?
                               MAX_SIDE : bnc_pkg::GRID_SIDE_RESET;
   localparam int GW = bnc_pkg::GRID_SIDE_W;
   localparam int OW = bnc_pkg::COORD_W;

   // side register, stored as side-1
   logic [PW-1:0] side_m1_ff, side_m1_in;

   // input cursor and row slot (row mod 3)
   logic [PW-1:0] in_row_ff, in_row_in;
   logic [PW-1:0] in_col_ff, in_col_in;
   logic [1:0]    in_slot_ff, in_slot_in;

   // emit cursor, trails the input cursor in raster order
   logic [PW-1:0] em_row_ff, em_row_in;
   logic [PW-1:0] em_col_ff, em_col_in;
   logic [1:0]    em_slot_ff, em_slot_in;

   // responses released but not yet loaded
   logic [CW-1:0] pend_ff, pend_in;

   // three stored rows, no reset
   logic [MAX_SIDE-1:0] rows_ff [3];

   // response register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [bnc_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [OW-1:0]               rsp_row_ff;
   logic [OW-1:0]               rsp_col_ff;
   logic                        rsp_last_ff;
   logic                        rsp_eof_ff;

   logic                        load;
   logic                        accept;
   logic [CW-1:0]               run_len;
   logic [CW-1:0]               side_ext;
   logic                        in_last_col;
   logic                        in_last_row;
   logic [1:0]                  up_slot;
   logic [1:0]                  dn_slot;
   logic [MAX_SIDE-1:0]         row_up;
   logic [MAX_SIDE-1:0]         row_mid;
   logic [MAX_SIDE-1:0]         row_dn;
   logic [bnc_pkg::COUNT_W-1:0] win_count;
   logic [PW+OW-1:0]            em_row_wide;
   logic [PW+OW-1:0]            em_col_wide;
   logic [PW+GW-1:0]            wdata_m1_wide;

   function automatic logic [1:0] slot_next(input logic [1:0] s);
      logic [1:0] r;
      case (s)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] slot_prev(input logic [1:0] s);
      logic [1:0] r;
      case (s)
         2'd1:    r = 2'd0;
         2'd2:    r = 2'd1;
         default: r = 2'd2;
      endcase
      return r;
   endfunction

   // handshake: a response is loaded when one is pending and the register frees
   assign load   = (pend_ff != '0) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = (pend_ff == '0) || ((pend_ff == CW'(1)) && load);
   assign accept = req_chan.valid && req_chan.ready;

   // how many responses this request releases
   assign in_last_col = (in_col_ff == side_m1_ff);
   assign in_last_row = (in_row_ff == side_m1_ff);
   assign side_ext    = CW'(side_m1_ff) + CW'(1);

   always_comb begin
      run_len = '0;
      if ((in_row_ff != '0) && (in_col_ff != '0)) begin
         run_len = run_len + CW'(1);
      end
      if ((in_row_ff != '0) && in_last_col) begin
         run_len = run_len + CW'(1);
      end
      if (in_last_row && in_last_col) begin
         run_len = run_len + side_ext;
      end
   end

   assign pend_in = pend_ff - CW'(load) + (accept ? run_len : '0);

   // input cursor advance
   always_comb begin
      in_row_in  = in_row_ff;
      in_col_in  = in_col_ff;
      in_slot_in = in_slot_ff;
      if (accept) begin
         if (in_last_col) begin
            in_col_in = '0;
            if (in_last_row) begin
               in_row_in  = '0;
               in_slot_in = 2'd0;
            end else begin
               in_row_in  = in_row_ff + PW'(1);
               in_slot_in = slot_next(in_slot_ff);
            end
         end else begin
            in_col_in = in_col_ff + PW'(1);
         end
      end
   end

   // emit cursor advance
   always_comb begin
      em_row_in  = em_row_ff;
      em_col_in  = em_col_ff;
      em_slot_in = em_slot_ff;
      if (load) begin
         if (em_col_ff == side_m1_ff) begin
            em_col_in = '0;
            if (em_row_ff == side_m1_ff) begin
               em_row_in  = '0;
               em_slot_in = 2'd0;
            end else begin
               em_row_in  = em_row_ff + PW'(1);
               em_slot_in = slot_next(em_slot_ff);
            end
         end else begin
            em_col_in = em_col_ff + PW'(1);
         end
      end
   end

   // side write: 0 acts as 1, above MAX_SIDE acts as MAX_SIDE
   assign wdata_m1_wide = {{PW{1'b0}}, csr_wdata - GW'(1)};

   always_comb begin
      if (csr_wdata == '0) begin
         side_m1_in = '0;
      end else if ({1'b0, csr_wdata} > (GW+1)'(MAX_SIDE)) begin
         side_m1_in = PW'(MAX_SIDE - 1);
      end else begin
         side_m1_in = wdata_m1_wide[PW-1:0];
      end
   end

   // window rows around the emit cursor
   assign up_slot = slot_prev(em_slot_ff);
   assign dn_slot = slot_next(em_slot_ff);

   always_comb begin
      row_up  = rows_ff[0];
      row_mid = rows_ff[0];
      row_dn  = rows_ff[0];
      for (int i = 1; i < 3; i++) begin
         if (up_slot == 2'(i)) begin
            row_up = rows_ff[i];
         end
         if (em_slot_ff == 2'(i)) begin
            row_mid = rows_ff[i];
         end
         if (dn_slot == 2'(i)) begin
            row_dn = rows_ff[i];
         end
      end
   end

   bnc_window #(
      .MAX_SIDE (MAX_SIDE)
   ) u_window (
      .row_up  (row_up),
      .row_mid (row_mid),
      .row_dn  (row_dn),
      .up_ok   (em_row_ff != '0),
      .dn_ok   (em_row_ff != side_m1_ff),
      .col     (em_col_ff),
      .side_m1 (side_m1_ff),
      .count   (win_count)
   );

   // coordinates out at the fixed field width
   assign em_row_wide = {{OW{1'b0}}, em_row_ff};
   assign em_col_wide = {{OW{1'b0}}, em_col_ff};

   assign rsp_valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         side_m1_ff   <= PW'(RESET_SIDE - 1);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= 2'd0;
         em_row_ff    <= '0;
         em_col_ff    <= '0;
         em_slot_ff   <= 2'd0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (csr_we) begin
         // new side restarts the frame
         side_m1_ff   <= side_m1_in;
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         in_slot_ff   <= 2'd0;
         em_row_ff    <= '0;
         em_col_ff    <= '0;
         em_slot_ff   <= 2'd0;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end else begin
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         in_slot_ff   <= in_slot_in;
         em_row_ff    <= em_row_in;
         em_col_ff    <= em_col_in;
         em_slot_ff   <= em_slot_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // row store write
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (accept && (in_slot_ff == 2'(i))) begin
            rows_ff[i][in_col_ff] <= req_chan.cell_set;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_count_ff <= win_count;
         rsp_row_ff   <= em_row_wide[OW-1:0];
         rsp_col_ff   <= em_col_wide[OW-1:0];
         rsp_last_ff  <= (pend_ff == CW'(1));
         rsp_eof_ff   <= (em_row_ff == side_m1_ff) && (em_col_ff == side_m1_ff);
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.neighbour_count = rsp_count_ff;
   assign rsp_chan.out_row         = rsp_row_ff;
   assign rsp_chan.out_col         = rsp_col_ff;
   assign rsp_chan.last_of_run     = rsp_last_ff;
   assign rsp_chan.end_of_frame    = rsp_eof_ff;

endmodule

FILE: rtl/bnc_window.sv
// bnc_window: counts the set cells of a 3x3 window taken from three stored rows
// depends on bnc_pkg for the count width

module bnc_window #(
   parameter int MAX_SIDE = bnc_pkg::MAX_SIDE_DEF
) (
   input  logic [MAX_SIDE-1:0]                                row_up,
   input  logic [MAX_SIDE-1:0]                                row_mid,
   input  logic [MAX_SIDE-1:0]                                row_dn,
   input  logic                                               up_ok,
   input  logic                                               dn_ok,
   input  logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] col,
   input  logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] side_m1,
   output logic [bnc_pkg::COUNT_W-1:0]                        count
);

   localparam int PW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;

   logic [MAX_SIDE-1:0]         rows [3];
   logic [2:0]                  row_ok;
   logic [PW-1:0]               col_left;
   logic [PW-1:0]               col_right;
   logic                        left_ok;
   logic                        right_ok;
   logic [bnc_pkg::COUNT_W-1:0] sum;

   assign rows[0]   = row_up;
   assign rows[1]   = row_mid;
   assign rows[2]   = row_dn;
   assign row_ok    = {dn_ok, 1'b1, up_ok};
   assign col_left  = col - PW'(1);
   assign col_right = col + PW'(1);
   assign left_ok   = (col != '0);
   assign right_ok  = (col != side_m1);

   always_comb begin
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         if (row_ok[i]) begin
            sum = sum + bnc_pkg::COUNT_W'(rows[i][col]);
            sum = sum + bnc_pkg::COUNT_W'(left_ok ? rows[i][col_left] : 1'b0);
            sum = sum + bnc_pkg::COUNT_W'(right_ok ? rows[i][col_right] : 1'b0);
         end
      end
   end

   assign count = sum;

endmodule

FILE: rtl/bnc_checker.sv
// bnc_checker: port-level assertions for the neighbour count unit, with bind
// depends on bnc_pkg and binary_3x3_neighbour_count_unit

module bnc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bnc_pkg::COUNT_W-1:0] neighbour_count,
   input logic [bnc_pkg::COORD_W-1:0] out_row,
   input logic [bnc_pkg::COORD_W-1:0] out_col,
   input logic                        last_of_run,
   input logic                        end_of_frame
);

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a window holds at most nine cells
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (neighbour_count <= bnc_pkg::COUNT_W'(bnc_pkg::COUNT_MAX)))
      else $error("count above nine");

   // bottom right cell ends the flush run
   a_eof_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && end_of_frame) |-> last_of_run)
      else $error("end of frame not last of run");

   // bottom right cell sits on the diagonal
   a_eof_diag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && end_of_frame) |-> (out_row == out_col))
      else $error("end of frame off the diagonal");

   // stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(neighbour_count)
         && $stable(out_row) && $stable(out_col) && $stable(last_of_run)
         && $stable(end_of_frame)))
      else $error("stalled response changed");

endmodule

bind binary_3x3_neighbour_count_unit bnc_checker u_bnc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .neighbour_count (rsp_chan.neighbour_count),
   .out_row         (rsp_chan.out_row),
   .out_col         (rsp_chan.out_col),
   .last_of_run     (rsp_chan.last_of_run),
   .end_of_frame    (rsp_chan.end_of_frame)
);
